/* hdl/png_unf_pkg.sv */
// ----------------------------------------------------------------------------
// png_unf_pkg
// Shared types and codes of the PNG scanline unfilter: filter types,
// configuration register indexes and the control word of a sample item.
// ----------------------------------------------------------------------------
package png_unf_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_PIXELS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd2;

	localparam logic [2:0] BPP_RESET    = 3'd4;
	localparam logic [12:0] WIDTH_RESET = 13'd1;
	localparam logic [15:0] HEIGHT_RESET = 16'd1;

	typedef enum logic [2:0] {
		FILT_NONE  = 3'd0,
		FILT_SUB   = 3'd1,
		FILT_UP    = 3'd2,
		FILT_AVG   = 3'd3,
		FILT_PAETH = 3'd4
	} filt_t;

	typedef struct packed {
		filt_t filt;
		logic  a_ok;
		logic  b_ok;
		logic  last_col;
		logic  last_row;
		logic  bad;
	} recon_ctl_t;

endpackage

/* hdl/png_unf_if.sv */
// ----------------------------------------------------------------------------
// png_unf_in_if / png_unf_out_if
// Valid/ready channels of the unfilter: inflated bytes in, pixel bytes out.
// ----------------------------------------------------------------------------
interface png_unf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

interface png_unf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;
	logic       row_end;
	logic       image_end;
	logic       bad_filter;

	modport source (output valid, output pixel_byte, output row_end,
		output image_end, output bad_filter, input ready);
	modport sink (input valid, input pixel_byte, input row_end,
		input image_end, input bad_filter, output ready);
endinterface

/* hdl/png_unf_cfg.sv */
// ----------------------------------------------------------------------------
// png_unf_cfg
// Configuration registers with range clamping; derives the row length.
// ----------------------------------------------------------------------------
module png_unf_cfg
	import png_unf_pkg::*;
#(
	parameter int MAX_WIDTH           = 4096,
	parameter int MAX_BYTES_PER_PIXEL = 4
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_we,
	input  logic [CFG_IDX_W-1:0]                          cfg_index,
	input  logic [CFG_DATA_W-1:0]                         cfg_data,
	output logic [$clog2(MAX_BYTES_PER_PIXEL+1)-1:0]      bpp_eff,
	output logic [$clog2(MAX_WIDTH*MAX_BYTES_PER_PIXEL+1)-1:0] row_len,
	output logic [15:0]                                   hgt_eff
);

	localparam int BPW = $clog2(MAX_BYTES_PER_PIXEL + 1);
	localparam int WDW = $clog2(MAX_WIDTH + 1);
	localparam int CW  = $clog2(MAX_WIDTH * MAX_BYTES_PER_PIXEL + 1);
	localparam int BCW = (BPW > 3) ? BPW : 3;
	localparam int WCW = (WDW > 13) ? WDW : 13;
	localparam int PW  = BPW + WDW;

	logic [2:0]     bpp_q;
	logic [12:0]    width_q;
	logic [15:0]    height_q;
	logic [BCW-1:0] bpp_ext;
	logic [WCW-1:0] wid_ext;
	logic [WDW-1:0] wid_eff;
	logic [PW-1:0]  prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q    <= BPP_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_BYTES_PER_PIXEL) bpp_q <= cfg_data[2:0];
			if (cfg_index == CFG_WIDTH_PIXELS) width_q <= cfg_data[12:0];
			if (cfg_index == CFG_IMAGE_HEIGHT) height_q <= cfg_data;
		end
	end

	always_comb begin
		bpp_ext = BCW'(bpp_q);
		wid_ext = WCW'(width_q);
		if (bpp_ext == '0) bpp_eff = BPW'(1);
		else if (bpp_ext > BCW'(MAX_BYTES_PER_PIXEL)) bpp_eff = BPW'(MAX_BYTES_PER_PIXEL);
		else bpp_eff = BPW'(bpp_ext);
		if (wid_ext == '0) wid_eff = WDW'(1);
		else if (wid_ext > WCW'(MAX_WIDTH)) wid_eff = WDW'(MAX_WIDTH);
		else wid_eff = WDW'(wid_ext);
		prod    = PW'(bpp_eff) * PW'(wid_eff);
		row_len = CW'(prod);
		hgt_eff = (height_q == 16'd0) ? 16'd1 : height_q;
	end

endmodule

/* hdl/png_unf_seq.sv */
// ----------------------------------------------------------------------------
// png_unf_seq
// Row and image sequencer: parses filter type bytes, tracks column, row,
// pixel slot and the sticky error, and issues sample and error items to the datapath.
// ----------------------------------------------------------------------------
module png_unf_seq
	import png_unf_pkg::*;
#(
	parameter int MAX_WIDTH           = 4096,
	parameter int MAX_BYTES_PER_PIXEL = 4
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic [$clog2(MAX_BYTES_PER_PIXEL+1)-1:0]           bpp_eff,
	input  logic [$clog2(MAX_WIDTH*MAX_BYTES_PER_PIXEL+1)-1:0] row_len,
	input  logic [15:0]                                        hgt_eff,
	input  logic                                               in_valid,
	input  logic [7:0]                                         in_byte,
	input  logic                                               take,
	output logic                                               push,
	output recon_ctl_t                                         push_ctl,
	output logic [$clog2(MAX_BYTES_PER_PIXEL)-1:0]             push_slot,
	output logic [$clog2(MAX_WIDTH*MAX_BYTES_PER_PIXEL)-1:0]   push_addr,
	output logic [7:0]                                         push_byte
);

	localparam int BPW = $clog2(MAX_BYTES_PER_PIXEL + 1);
	localparam int SW  = $clog2(MAX_BYTES_PER_PIXEL);
	localparam int CW  = $clog2(MAX_WIDTH * MAX_BYTES_PER_PIXEL + 1);
	localparam int AW  = $clog2(MAX_WIDTH * MAX_BYTES_PER_PIXEL);

	logic [CW-1:0]  col_q;
	logic [15:0]    row_q;
	filt_t          filt_q;
	logic           err_q;
	logic [SW-1:0]  mod_q [MAX_BYTES_PER_PIXEL];

	logic           fire;
	logic           is_filt;
	logic           bad;
	logic           last_col;
	logic           last_row;
	logic [BPW-1:0] bpp_m1;
	logic [CW-1:0]  x;
	logic [16:0]    row_next;

	always_comb begin
		fire      = in_valid && take;
		is_filt   = (col_q == '0);
		bad       = in_byte > {5'd0, FILT_PAETH};
		x         = col_q - CW'(1);
		row_next  = {1'b0, row_q} + 17'd1;
		last_col  = col_q >= row_len;
		last_row  = row_next >= {1'b0, hgt_eff};
		bpp_m1    = bpp_eff - BPW'(1);

		push      = fire && !err_q && (!is_filt || bad);
		push_byte = in_byte;
		push_slot = mod_q[bpp_m1[SW-1:0]];
		push_addr = x[AW-1:0];
		push_ctl.filt     = filt_q;
		push_ctl.a_ok     = x >= CW'(bpp_eff);
		push_ctl.b_ok     = (row_q != 16'd0);
		push_ctl.last_col = last_col;
		push_ctl.last_row = last_row;
		push_ctl.bad      = is_filt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			filt_q <= FILT_NONE;
			err_q  <= 1'b0;
			for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++)
				mod_q[i] <= '0;
		end else if (fire) begin
			if (is_filt) begin
				col_q <= CW'(1);
				for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++)
					mod_q[i] <= '0;
				if (!err_q) begin
					if (bad) err_q <= 1'b1;
					else filt_q <= filt_t'(in_byte[2:0]);
				end
			end else begin
				// column modulo each possible pixel size
				for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++)
					mod_q[i] <= (mod_q[i] == SW'(i)) ? '0 : mod_q[i] + SW'(1);
				if (last_col) begin
					col_q <= '0;
					if (last_row) begin
						row_q <= '0;
						err_q <= 1'b0;
					end else begin
						row_q <= row_next[15:0];
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

endmodule

/* hdl/png_unf_recon.sv */
// ----------------------------------------------------------------------------
// png_unf_recon
// Line buffer and reconstruction stage: reads the byte above, applies the
// row filter against the left, above and upper-left bytes, writes the row back and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module png_unf_recon
	import png_unf_pkg::*;
#(
	parameter int MAX_WIDTH           = 4096,
	parameter int MAX_BYTES_PER_PIXEL = 4
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             push,
	input  recon_ctl_t                                       push_ctl,
	input  logic [$clog2(MAX_BYTES_PER_PIXEL)-1:0]           push_slot,
	input  logic [$clog2(MAX_WIDTH*MAX_BYTES_PER_PIXEL)-1:0] push_addr,
	input  logic [7:0]                                       push_byte,
	output logic                                             take,
	output logic                                             out_valid,
	input  logic                                             out_ready,
	output logic [7:0]                                       out_pixel,
	output logic                                             out_row_end,
	output logic                                             out_image_end,
	output logic                                             out_bad
);

	localparam int SW    = $clog2(MAX_BYTES_PER_PIXEL);
	localparam int AW    = $clog2(MAX_WIDTH * MAX_BYTES_PER_PIXEL);
	localparam int DEPTH = MAX_WIDTH * MAX_BYTES_PER_PIXEL;

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c);
		logic signed [10:0] pa;
		logic signed [10:0] pb;
		logic signed [10:0] pc;
		pa = $signed({3'd0, b}) - $signed({3'd0, c});
		pb = $signed({3'd0, a}) - $signed({3'd0, c});
		pc = pa + pb;
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		if (pa <= pb && pa <= pc) return a;
		if (pb <= pc) return b;
		return c;
	endfunction

	logic [7:0]    line_mem [DEPTH];
	logic [7:0]    left_q [MAX_BYTES_PER_PIXEL];
	logic [7:0]    upleft_q [MAX_BYTES_PER_PIXEL];

	logic          valid_s1;
	recon_ctl_t    ctl_s1;
	logic [SW-1:0] slot_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    byte_s1;
	logic [7:0]    above_s1;

	logic          out_valid_q;
	logic [7:0]    pixel_q;
	logic          row_end_q;
	logic          image_end_q;
	logic          bad_q;

	logic          adv;
	logic [7:0]    a;
	logic [7:0]    b;
	logic [7:0]    c;
	logic [8:0]    ab_sum;
	logic [7:0]    pred;
	logic [7:0]    val;

	always_comb begin
		adv    = valid_s1 && (!out_valid_q || out_ready);
		take   = !valid_s1 || adv;
		a      = ctl_s1.a_ok ? left_q[slot_s1] : 8'd0;
		b      = ctl_s1.b_ok ? above_s1 : 8'd0;
		c      = (ctl_s1.a_ok && ctl_s1.b_ok) ? upleft_q[slot_s1] : 8'd0;
		ab_sum = {1'b0, a} + {1'b0, b};
		unique case (ctl_s1.filt)
			FILT_NONE:  pred = 8'd0;
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = ab_sum[8:1];
			FILT_PAETH: pred = paeth(a, b, c);
			default:    pred = 8'd0;
		endcase
		val = byte_s1 + pred;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			above_s1 <= line_mem[push_addr];
			ctl_s1   <= push_ctl;
			slot_s1  <= push_slot;
			addr_s1  <= push_addr;
			byte_s1  <= push_byte;
		end
		if (adv && !ctl_s1.bad)
			line_mem[addr_s1] <= val;
		if (adv) begin
			pixel_q     <= ctl_s1.bad ? 8'd0 : val;
			row_end_q   <= !ctl_s1.bad && ctl_s1.last_col;
			image_end_q <= !ctl_s1.bad && ctl_s1.last_col && ctl_s1.last_row;
			bad_q       <= ctl_s1.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
				left_q[i]   <= 8'd0;
				upleft_q[i] <= 8'd0;
			end
		end else begin
			if (push) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (adv && !ctl_s1.bad) begin
				left_q[slot_s1]   <= val;
				upleft_q[slot_s1] <= b;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_pixel     = pixel_q;
	assign out_row_end   = row_end_q;
	assign out_image_end = image_end_q;
	assign out_bad       = bad_q;

endmodule

/* hdl/png_scanline_unfilter_core.sv */
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core
// PNG scanline unfilter (None, Sub, Up, Average, Paeth) over an inflated
// byte stream, with a one-row line buffer.
//
//   channel   dir   payload                                     per item
//   stream    in    stream_byte                                 filter or sample
//   pixels    out   pixel_byte, row_end, image_end, bad_filter  one result
//   cfg       in    cfg_index, cfg_data (write only)            one register
//
// One item per cycle sustained while the output is not stalled; a sample taken passes through the
// reconstruction stage register and then the output register. The line buffer read is issued when a
// sample is taken; filtering, the left byte feedback and the write-back run in the single reconstruction stage.
// Reset clears control state and the left and upper-left bytes; the line
// buffer is not cleared.
// A stalled output holds the reconstruction stage, then the input.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_core
	import png_unf_pkg::*;
#(
	parameter int MAX_WIDTH           = 4096,
	parameter int MAX_BYTES_PER_PIXEL = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	png_unf_in_if.sink            stream,
	png_unf_out_if.source         pixels
);

	localparam int BPW = $clog2(MAX_BYTES_PER_PIXEL + 1);
	localparam int SW  = $clog2(MAX_BYTES_PER_PIXEL);
	localparam int CW  = $clog2(MAX_WIDTH * MAX_BYTES_PER_PIXEL + 1);
	localparam int AW  = $clog2(MAX_WIDTH * MAX_BYTES_PER_PIXEL);

	logic [BPW-1:0] bpp_eff;
	logic [CW-1:0]  row_len;
	logic [15:0]    hgt_eff;
	logic           take;
	logic           push;
	recon_ctl_t     push_ctl;
	logic [SW-1:0]  push_slot;
	logic [AW-1:0]  push_addr;
	logic [7:0]     push_byte;

	png_unf_cfg #(
		.MAX_WIDTH           (MAX_WIDTH),
		.MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bpp_eff   (bpp_eff),
		.row_len   (row_len),
		.hgt_eff   (hgt_eff)
	);

	png_unf_seq #(
		.MAX_WIDTH           (MAX_WIDTH),
		.MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.bpp_eff   (bpp_eff),
		.row_len   (row_len),
		.hgt_eff   (hgt_eff),
		.in_valid  (stream.valid),
		.in_byte   (stream.stream_byte),
		.take      (take),
		.push      (push),
		.push_ctl  (push_ctl),
		.push_slot (push_slot),
		.push_addr (push_addr),
		.push_byte (push_byte)
	);

	png_unf_recon #(
		.MAX_WIDTH           (MAX_WIDTH),
		.MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
	) u_recon (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.push_ctl      (push_ctl),
		.push_slot     (push_slot),
		.push_addr     (push_addr),
		.push_byte     (push_byte),
		.take          (take),
		.out_valid     (pixels.valid),
		.out_ready     (pixels.ready),
		.out_pixel     (pixels.pixel_byte),
		.out_row_end   (pixels.row_end),
		.out_image_end (pixels.image_end),
		.out_bad       (pixels.bad_filter)
	);

	assign stream.ready = take;

endmodule

/* hdl/png_unf_chk.sv */
// ----------------------------------------------------------------------------
// png_unf_chk
// Port-level checks of the unfilter result channel, bound to the core.
// ----------------------------------------------------------------------------
module png_unf_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] pixel_byte,
	input logic       row_end,
	input logic       image_end,
	input logic       bad_filter
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_byte)
		&& $stable(row_end) && $stable(image_end) && $stable(bad_filter))
		else $error("result item changed while stalled");

	a_drop_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result item dropped before taken");

	a_error_item_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_filter |-> pixel_byte == 8'd0 && !row_end && !image_end)
		else $error("error item carries sample fields");

	a_image_end_on_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_end |-> row_end)
		else $error("image end without row end");

endmodule

bind png_scanline_unfilter_core png_unf_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (pixels.valid),
	.out_ready  (pixels.ready),
	.pixel_byte (pixels.pixel_byte),
	.row_end    (pixels.row_end),
	.image_end  (pixels.image_end),
	.bad_filter (pixels.bad_filter)
);
